/* src/itrt_pkg.sv */
// Shared types, constants and the digit-to-character function of the
// integer-to-radix-text core. No dependencies.
package itrt_pkg;

   // Default sizes and fixed field widths.
   localparam int VALUE_WIDTH_DEF = 32;
   localparam int MAX_DIGITS_DEF  = 32;
   localparam int RAW_W           = 32;
   localparam int CHAR_W          = 8;
   localparam int CSR_INDEX_W     = 8;
   localparam int CSR_DATA_W      = 8;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIX_MODE     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_CASE_HEX = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGN_MODE      = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_PREFIX    = 8'd3;

   // Sign mode codes; the unused code behaves as no sign.
   localparam logic [1:0] SIGN_MODE_PLUS  = 2'd1;
   localparam logic [1:0] SIGN_MODE_SPACE = 2'd2;

   // ASCII codes used by the formatter.
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_LOWER_B = 8'h62;
   localparam logic [CHAR_W-1:0] CH_LOWER_O = 8'h6F;
   localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_BIN,
      RADIX_OCT,
      RADIX_HEX
   } radix_type;

   // Configuration register set.
   typedef struct packed {
      radix_type  radix_mode;
      logic       upper_case_hex;
      logic [1:0] sign_mode;
      logic       show_prefix;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_PREFIX_ZERO,
      ST_PREFIX_LETTER,
      ST_DIGITS
   } state_type;

   typedef enum logic [1:0] {
      CHAR_SIGN,
      CHAR_ZERO,
      CHAR_LETTER,
      CHAR_DIGIT
   } char_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         load;
      logic         convert;
      logic         pos_dec;
      logic         emit;
      logic         last;
      char_sel_type char_sel;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic conv_done;
      logic skip_ok;
      logic pos_zero;
      logic has_sign;
      logic has_prefix;
      logic is_decimal;
   } dp_status_type;

   // Maps a digit value to its ASCII character.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] digit,
                                                    input logic       upper);
      logic [CHAR_W-1:0] base_char;
      if (digit < 4'd10) begin
         digit_char = CH_ZERO + {4'b0000, digit};
      end else begin
         base_char  = upper ? CH_UPPER_A : CH_LOWER_A;
         digit_char = base_char + {4'b0000, digit} - 8'd10;
      end
   endfunction

endpackage

/* src/itrt_csr.sv */
// Configuration registers of the integer-to-radix-text core.
// Depends on itrt_pkg.
module itrt_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [itrt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [itrt_pkg::CSR_DATA_W-1:0]   csr_data,
   output itrt_pkg::cfg_type                 cfg
);
   import itrt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken; an index beyond the list is ignored.
   assign csr_ready = 1'b1;

   // Register update for one written word.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_RADIX_MODE:     cfg_in.radix_mode     = radix_type'(csr_data[1:0]);
            CSR_UPPER_CASE_HEX: cfg_in.upper_case_hex = csr_data[0];
            CSR_SIGN_MODE:      cfg_in.sign_mode      = csr_data[1:0];
            CSR_SHOW_PREFIX:    cfg_in.show_prefix    = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{radix_mode: RADIX_DEC, upper_case_hex: 1'b0,
                     sign_mode: 2'b00, show_prefix: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/itrt_ctrl.sv */
// Controller state machine of the integer-to-radix-text core: sequences
// conversion, leading-zero skip and character output. Depends on itrt_pkg.
module itrt_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  itrt_pkg::dp_status_type  status,
   output itrt_pkg::ctrl_cmd_type   cmd
);
   import itrt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = status.is_decimal ? ST_CONVERT : ST_SKIP;
            end
         end
         ST_CONVERT: begin
            if (status.conv_done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!status.skip_ok) begin
               if (status.has_sign) begin
                  state_in = ST_SIGN;
               end else if (status.has_prefix) begin
                  state_in = ST_PREFIX_ZERO;
               end else begin
                  state_in = ST_DIGITS;
               end
            end
         end
         ST_SIGN: begin
            state_in = status.has_prefix ? ST_PREFIX_ZERO : ST_DIGITS;
         end
         ST_PREFIX_ZERO:   state_in = ST_PREFIX_LETTER;
         ST_PREFIX_LETTER: state_in = ST_DIGITS;
         ST_DIGITS: begin
            if (status.pos_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands for each state.
   always_comb begin
      cmd.load     = 1'b0;
      cmd.convert  = 1'b0;
      cmd.pos_dec  = 1'b0;
      cmd.emit     = 1'b0;
      cmd.last     = 1'b0;
      cmd.char_sel = CHAR_DIGIT;
      case (state_ff)
         ST_IDLE:    cmd.load = start;
         ST_CONVERT: cmd.convert = 1'b1;
         ST_SKIP:    cmd.pos_dec = status.skip_ok;
         ST_SIGN: begin
            cmd.emit     = 1'b1;
            cmd.char_sel = CHAR_SIGN;
         end
         ST_PREFIX_ZERO: begin
            cmd.emit     = 1'b1;
            cmd.char_sel = CHAR_ZERO;
         end
         ST_PREFIX_LETTER: begin
            cmd.emit     = 1'b1;
            cmd.char_sel = CHAR_LETTER;
         end
         ST_DIGITS: begin
            cmd.emit     = 1'b1;
            cmd.char_sel = CHAR_DIGIT;
            cmd.last     = status.pos_zero;
            cmd.pos_dec  = !status.pos_zero;
         end
         default: cmd.load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* src/itrt_datapath.sv */
// Datapath of the integer-to-radix-text core: magnitude, shift-add-3 decimal
// converter, digit position counter and registered result word.
// Depends on itrt_pkg.
module itrt_datapath #(
   parameter int VALUE_WIDTH = itrt_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = itrt_pkg::MAX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [itrt_pkg::RAW_W-1:0]    req_raw_value,
   input  logic                          req_is_signed,
   input  itrt_pkg::cfg_type             cfg,
   input  itrt_pkg::ctrl_cmd_type        cmd,
   output itrt_pkg::dp_status_type       status,
   output logic                          rsp_strobe,
   output logic [itrt_pkg::CHAR_W-1:0]   rsp_char_code,
   output logic                          rsp_last_char
);
   import itrt_pkg::*;

   // Digit counts of a full-width value in each radix.
   localparam int NUM_BIN = VALUE_WIDTH;
   localparam int NUM_OCT = (VALUE_WIDTH + 2) / 3;
   localparam int NUM_HEX = (VALUE_WIDTH + 3) / 4;
   localparam int NUM_DEC = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_W   = 4 * NUM_DEC;
   localparam int OCT_W   = 3 * NUM_OCT;
   localparam int HEX_W   = 4 * NUM_HEX;
   localparam int EXT_W   = (VALUE_WIDTH > RAW_W) ? VALUE_WIDTH : RAW_W;

   // Index widths of the digit position and of each digit array.
   localparam int POS_W  = $clog2(NUM_BIN);
   localparam int OCT_IW = (NUM_OCT > 1) ? $clog2(NUM_OCT) : 1;
   localparam int HEX_IW = (NUM_HEX > 1) ? $clog2(NUM_HEX) : 1;
   localparam int DEC_IW = (NUM_DEC > 1) ? $clog2(NUM_DEC) : 1;
   localparam int CNT_W  = $clog2(VALUE_WIDTH);

   // Position of the most significant digit that is kept, per radix.
   localparam int TOP_BIN = ((NUM_BIN < MAX_DIGITS) ? NUM_BIN : MAX_DIGITS) - 1;
   localparam int TOP_OCT = ((NUM_OCT < MAX_DIGITS) ? NUM_OCT : MAX_DIGITS) - 1;
   localparam int TOP_HEX = ((NUM_HEX < MAX_DIGITS) ? NUM_HEX : MAX_DIGITS) - 1;
   localparam int TOP_DEC = ((NUM_DEC < MAX_DIGITS) ? NUM_DEC : MAX_DIGITS) - 1;

   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic                   neg_ff, neg_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rsp_strobe_ff;
   logic [CHAR_W-1:0]      rsp_char_ff;
   logic                   rsp_last_ff;

   logic [EXT_W-1:0]       raw_ext;
   logic [VALUE_WIDTH-1:0] value_bits;
   logic                   value_neg;
   logic [BCD_W-1:0]       bcd_adj;
   logic [POS_W-1:0]       start_pos;
   logic [OCT_W-1:0]       oct_vec;
   logic [HEX_W-1:0]       hex_vec;
   logic [3:0]             oct_digits [NUM_OCT];
   logic [3:0]             hex_digits [NUM_HEX];
   logic [3:0]             dec_digits [NUM_DEC];
   logic [3:0]             cur_digit;
   logic                   upper_nz;
   logic [CHAR_W-1:0]      sign_char;
   logic [CHAR_W-1:0]      letter_char;
   logic [CHAR_W-1:0]      out_char;

   // Input value, taken to the configured width.
   assign raw_ext    = EXT_W'(req_raw_value);
   assign value_bits = raw_ext[VALUE_WIDTH-1:0];
   assign value_neg  = req_is_signed & value_bits[VALUE_WIDTH-1];

   // Starting digit position for the configured radix.
   always_comb begin
      case (cfg.radix_mode)
         RADIX_BIN: start_pos = POS_W'(TOP_BIN);
         RADIX_OCT: start_pos = POS_W'(TOP_OCT);
         RADIX_HEX: start_pos = POS_W'(TOP_HEX);
         default:   start_pos = POS_W'(TOP_DEC);
      endcase
   end

   // Add 3 to every BCD digit of 5 or more before the next shift.
   always_comb begin
      for (int i = 0; i < NUM_DEC; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                             bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
   end

   // Working register updates.
   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      pos_in = pos_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         neg_in = value_neg;
         mag_in = value_neg ? (~value_bits) + VALUE_WIDTH'(1) : value_bits;
         bcd_in = '0;
         cnt_in = '0;
         pos_in = start_pos;
      end else if (cmd.convert) begin
         bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.pos_dec) begin
         pos_in = pos_ff - POS_W'(1);
      end
   end

   // Digit views of the magnitude and of the BCD register.
   assign oct_vec = OCT_W'(mag_ff);
   assign hex_vec = HEX_W'(mag_ff);

   always_comb begin
      for (int i = 0; i < NUM_OCT; i++) begin
         oct_digits[i] = {1'b0, oct_vec[3*i +: 3]};
      end
      for (int i = 0; i < NUM_HEX; i++) begin
         hex_digits[i] = hex_vec[4*i +: 4];
      end
      for (int i = 0; i < NUM_DEC; i++) begin
         dec_digits[i] = bcd_ff[4*i +: 4];
      end
   end

   // Current digit and whether digits beyond the kept window are nonzero.
   always_comb begin
      case (cfg.radix_mode)
         RADIX_BIN: begin
            cur_digit = {3'b000, mag_ff[pos_ff]};
            upper_nz  = (mag_ff >> MAX_DIGITS) != '0;
         end
         RADIX_OCT: begin
            cur_digit = oct_digits[pos_ff[OCT_IW-1:0]];
            upper_nz  = (mag_ff >> (3 * MAX_DIGITS)) != '0;
         end
         RADIX_HEX: begin
            cur_digit = hex_digits[pos_ff[HEX_IW-1:0]];
            upper_nz  = (mag_ff >> (4 * MAX_DIGITS)) != '0;
         end
         default: begin
            cur_digit = dec_digits[pos_ff[DEC_IW-1:0]];
            upper_nz  = (bcd_ff >> (4 * MAX_DIGITS)) != '0;
         end
      endcase
   end

   // Status toward the controller.
   always_comb begin
      status.conv_done  = (cnt_ff == CNT_W'(VALUE_WIDTH - 1));
      status.pos_zero   = (pos_ff == '0);
      status.skip_ok    = (cur_digit == 4'd0) && (pos_ff != '0) && !upper_nz;
      status.has_sign   = neg_ff || (cfg.sign_mode == SIGN_MODE_PLUS) ||
                          (cfg.sign_mode == SIGN_MODE_SPACE);
      status.has_prefix = cfg.show_prefix && (cfg.radix_mode != RADIX_DEC);
      status.is_decimal = (cfg.radix_mode == RADIX_DEC);
   end

   // Character selection.
   always_comb begin
      if (neg_ff) begin
         sign_char = CH_MINUS;
      end else if (cfg.sign_mode == SIGN_MODE_PLUS) begin
         sign_char = CH_PLUS;
      end else begin
         sign_char = CH_SPACE;
      end
      case (cfg.radix_mode)
         RADIX_BIN: letter_char = CH_LOWER_B;
         RADIX_OCT: letter_char = CH_LOWER_O;
         default:   letter_char = CH_LOWER_X;
      endcase
      case (cmd.char_sel)
         CHAR_SIGN:   out_char = sign_char;
         CHAR_ZERO:   out_char = CH_ZERO;
         CHAR_LETTER: out_char = letter_char;
         default:     out_char = digit_char(cur_digit, cfg.upper_case_hex);
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
         neg_ff        <= 1'b0;
         pos_ff        <= '0;
         cnt_ff        <= '0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
         neg_ff        <= neg_in;
         pos_ff        <= pos_in;
         cnt_ff        <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      rsp_char_ff <= out_char;
      rsp_last_ff <= cmd.last;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

/* src/integer_to_radix_text_core.sv */
// Integer-to-radix-text core: one start word in, one ASCII character word
// out per strobe, last character flagged. The result side cannot be stalled:
// every character is presented on rsp_char_code for exactly one cycle with
// rsp_strobe high and must be captured then. An item runs through a start
// step, then the shift-add-3 conversion in decimal only, then a skip of the
// leading zero digits, then the characters (sign, two prefix characters,
// digits). Each skipped zero digit is not output. start is accepted
// whenever busy is low; the final character is on the result ports in the
// first cycle with busy low.
// Depends on itrt_pkg, itrt_csr, itrt_ctrl and itrt_datapath.
module integer_to_radix_text_core #(
   parameter int VALUE_WIDTH = itrt_pkg::VALUE_WIDTH_DEF,
   parameter int MAX_DIGITS  = itrt_pkg::MAX_DIGITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [itrt_pkg::RAW_W-1:0]        req_raw_value,
   input  logic                              req_is_signed,
   output logic                              rsp_strobe,
   output logic [itrt_pkg::CHAR_W-1:0]       rsp_char_code,
   output logic                              rsp_last_char,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [itrt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [itrt_pkg::CSR_DATA_W-1:0]   csr_data
);
   import itrt_pkg::*;

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Configuration registers.
   itrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Sequencer.
   itrt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Conversion and character datapath.
   itrt_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .MAX_DIGITS  (MAX_DIGITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_raw_value (req_raw_value),
      .req_is_signed (req_is_signed),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .rsp_strobe    (rsp_strobe),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule
